/* hw/rtl/dfrq_pkg.sv */
// ----------------------------------------------------------------------------
// dfrq_pkg: shared types and constants of the delimited frame receiver
// Sizes of the frame queue, marker bytes, mode and result codes, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dfrq_pkg;

  // Queue geometry
  localparam int MAX_FRAME_LEN = 64;
  localparam int QUEUE_DEPTH   = 8;
  // One spare slot so a frame under assembly never lands on a stored one
  localparam int SLOTS         = QUEUE_DEPTH + 1;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W         = $clog2(MAX_FRAME_LEN);
  localparam int ADDR_W        = $clog2(SLOTS * MAX_FRAME_LEN);

  // Display buffer geometry
  localparam int DISP_COLS = 128;
  localparam int DISP_ROWS = 8;
  localparam int COL_W     = $clog2(DISP_COLS);
  localparam int ROW_W     = $clog2(DISP_ROWS);

  // Marker bytes
  localparam logic [7:0] START_MARK = 8'h23;
  localparam logic [7:0] END_MARK   = 8'h21;

  // Mode register codes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_DISPLAY  = 2'd1;
  localparam logic [1:0] MODE_FRAME    = 2'd2;
  localparam logic [1:0] MODE_NONE_ALT = 2'd3;

  // Request kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] RK_DISPLAY     = 2'd0;
  localparam logic [1:0] RK_FRAME_BYTE  = 2'd1;
  localparam logic [1:0] RK_QUEUE_EMPTY = 2'd2;
  localparam logic [1:0] RK_EMPTY_FRAME = 2'd3;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [ROW_W-1:0] fb_row;
    logic [COL_W-1:0] fb_col;
    logic [7:0]       data_byte;
    logic             last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic byte_take;  // received byte accepted
    logic rd_take;    // read request accepted
    logic rd_next;    // frame byte delivered, more follow
    logic rd_pop;     // last frame byte delivered, drop head frame
    logic sel_frame;  // result comes from the frame memory
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode_display;   // a byte yields a display write
    logic q_empty;
    logic head_len_zero;
    logic rd_last;        // current read index is the frame's last byte
  } status_t;

endpackage

/* hw/rtl/dfrq_if.sv */
// ----------------------------------------------------------------------------
// dfrq_if: request and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface dfrq_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface dfrq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] fb_row;
  logic [6:0] fb_col;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output result_kind, output fb_row, output fb_col,
                  output data_byte, output last, input ready);
  modport sink   (input valid, input result_kind, input fb_row, input fb_col,
                  input data_byte, input last, output ready);
endinterface

/* hw/rtl/dfrq_datapath.sv */
// ----------------------------------------------------------------------------
// dfrq_datapath: parser, frame queue and display position
// Holds the mode register, frame memory, length table, queue pointers and
// the single-result register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module dfrq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic [7:0]        rx_byte,
  input  dfrq_pkg::cmd_t    cmd,
  output dfrq_pkg::status_t status,
  output dfrq_pkg::result_t result
);
  import dfrq_pkg::*;

  // Control registers
  logic [1:0]        op_mode;
  logic              receiving;
  logic [LEN_W-1:0]  collect_cnt;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [ROW_W-1:0]  disp_row;
  logic [COL_W-1:0]  disp_col;

  // Storage and payload
  logic [7:0]        frame_mem [SLOTS*MAX_FRAME_LEN];
  logic [LEN_W-1:0]  frame_len [SLOTS];
  logic [7:0]        rd_q;
  logic [LEN_W-1:0]  rd_idx;
  result_t           single;

  logic              q_full;
  logic              frame_byte;
  logic              wr_en;
  logic              len_we;
  logic              pop;
  logic [LEN_W-1:0]  head_len;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0]  i);
    slot_addr = ADDR_W'(s) * ADDR_W'(MAX_FRAME_LEN) + ADDR_W'(i);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Decode of the current operation
  assign q_full     = (count == CNT_W'(QUEUE_DEPTH));
  assign frame_byte = cmd.byte_take && (op_mode == MODE_FRAME) && receiving;
  assign wr_en      = frame_byte && (rx_byte != END_MARK) &&
                      (collect_cnt != LEN_W'(MAX_FRAME_LEN - 1));
  assign len_we     = frame_byte && (rx_byte == END_MARK) && !q_full;
  assign head_len   = frame_len[head];
  assign pop        = cmd.rd_pop ||
                      (cmd.rd_take && (count != '0) && (head_len == '0));
  assign wr_addr    = slot_addr(tail, collect_cnt);
  assign rd_addr    = slot_addr(head, rd_idx);

  // Status to controller
  assign status.mode_display  = (op_mode == MODE_DISPLAY);
  assign status.q_empty       = (count == '0);
  assign status.head_len_zero = (head_len == '0);
  assign status.rd_last       = ({1'b0, rd_idx} + (LEN_W+1)'(1)) == {1'b0, head_len};

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= MODE_NONE;
      receiving   <= 1'b0;
      collect_cnt <= '0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      disp_row    <= '0;
      disp_col    <= '0;
    end else if (cfg_we) begin
      op_mode     <= cfg_wdata;
      receiving   <= 1'b0;
      collect_cnt <= '0;
      unique case (cfg_wdata) inside
        MODE_FRAME: ;
        MODE_DISPLAY: begin
          disp_row <= '0;
          disp_col <= '0;
        end
        MODE_NONE, MODE_NONE_ALT: begin
          disp_row <= '0;
          disp_col <= '0;
          head     <= '0;
          tail     <= '0;
          count    <= '0;
        end
        default: ;
      endcase
    end else begin
      // received byte
      if (cmd.byte_take) begin
        unique case (op_mode) inside
          MODE_DISPLAY: begin
            if (disp_col == COL_W'(DISP_COLS - 1)) begin
              disp_col <= '0;
              disp_row <= (disp_row == ROW_W'(DISP_ROWS - 1)) ? '0
                                                              : disp_row + ROW_W'(1);
            end else begin
              disp_col <= disp_col + COL_W'(1);
            end
          end
          MODE_FRAME: begin
            if (!receiving) begin
              if (rx_byte == START_MARK) begin
                receiving   <= 1'b1;
                collect_cnt <= '0;
              end
            end else if (rx_byte == END_MARK) begin
              if (!q_full) begin
                tail  <= next_slot(tail);
                count <= count + CNT_W'(1);
              end
              receiving   <= 1'b0;
              collect_cnt <= '0;
            end else if (wr_en) begin
              collect_cnt <= collect_cnt + LEN_W'(1);
            end else begin
              // overlong frame
              receiving   <= 1'b0;
              collect_cnt <= '0;
            end
          end
          MODE_NONE, MODE_NONE_ALT: ;
          default: ;
        endcase
      end
      // frame removed from the queue
      if (pop) begin
        head  <= next_slot(head);
        count <= count - CNT_W'(1);
      end
    end
  end

  // Single-result register and read index
  always_ff @(posedge clk) begin
    if (cmd.byte_take) begin
      single.result_kind <= RK_DISPLAY;
      single.fb_row      <= disp_row;
      single.fb_col      <= disp_col;
      single.data_byte   <= rx_byte;
      single.last        <= 1'b0;
    end else if (cmd.rd_take) begin
      single.result_kind <= (count == '0) ? RK_QUEUE_EMPTY : RK_EMPTY_FRAME;
      single.fb_row      <= '0;
      single.fb_col      <= '0;
      single.data_byte   <= '0;
      single.last        <= 1'b1;
    end
    if (cmd.rd_take) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + LEN_W'(1);
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= rx_byte;
    end
    rd_q <= frame_mem[rd_addr];
  end

  // Length table
  always_ff @(posedge clk) begin
    if (len_we) begin
      frame_len[tail] <= collect_cnt;
    end
  end

  // Result mux
  always_comb begin
    if (cmd.sel_frame) begin
      result.result_kind = RK_FRAME_BYTE;
      result.fb_row      = '0;
      result.fb_col      = '0;
      result.data_byte   = rd_q;
      result.last        = status.rd_last;
    end else begin
      result = single;
    end
  end

endmodule

/* hw/rtl/dfrq_ctrl.sv */
// ----------------------------------------------------------------------------
// dfrq_ctrl: handshake and sequencing controller
// Accepts one request at a time, issues datapath commands and presents
// results on the output channel.
// ----------------------------------------------------------------------------
module dfrq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dfrq_pkg::status_t status,
  output dfrq_pkg::cmd_t    cmd
);
  import dfrq_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RESULT,
    RD_FETCH,
    RD_SHOW
  } state_t;

  state_t state;
  logic   in_fire;
  logic   out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Commands
  always_comb begin
    cmd.byte_take = in_fire && (in_kind == KIND_BYTE);
    cmd.rd_take   = in_fire && (in_kind == KIND_READ);
    cmd.rd_next   = (state == RD_SHOW) && out_fire && !status.rd_last;
    cmd.rd_pop    = (state == RD_SHOW) && out_fire && status.rd_last;
    cmd.sel_frame = (state == RD_SHOW);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            if (in_kind == KIND_READ) begin
              in_ready <= 1'b0;
              if (status.q_empty || status.head_len_zero) begin
                state     <= RESULT;
                out_valid <= 1'b1;
              end else begin
                state <= RD_FETCH;
              end
            end else if (status.mode_display) begin
              state     <= RESULT;
              in_ready  <= 1'b0;
              out_valid <= 1'b1;
            end
          end
        end
        RESULT: begin
          if (out_fire) begin
            state     <= IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b0;
          end
        end
        RD_FETCH: begin
          state     <= RD_SHOW;
          out_valid <= 1'b1;
        end
        RD_SHOW: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            if (status.rd_last) begin
              state    <= IDLE;
              in_ready <= 1'b1;
            end else begin
              state <= RD_FETCH;
            end
          end
        end
        default: begin
          state     <= IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/delimited_frame_receiver_queue.sv */
// ----------------------------------------------------------------------------
// delimited_frame_receiver_queue: framed byte receiver with a frame queue
//
//   channel   dir  payload                                       handshake
//   req       in   kind, rx_byte                                 valid/ready
//   rsp       out  result_kind, fb_row, fb_col, data_byte, last  valid/ready
//   cfg       in   cfg_wdata (op_mode)                           cfg_we
//
// A received byte yields a result only in display mode. A read of a frame
// passes through RD_FETCH and RD_SHOW for each frame byte, as the read port
// of the frame memory is registered; an empty queue or an empty frame gives
// a single empty result.
// One request is in flight at a time; ready drops until its results are taken.
// Reset is synchronous; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_queue (
  input  logic       clk,
  input  logic       rst,
  dfrq_req_if.sink   req,
  dfrq_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import dfrq_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  // Controller
  dfrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.kind),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  dfrq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (req.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // Result payload
  assign rsp.result_kind = result.result_kind;
  assign rsp.fb_row      = result.fb_row;
  assign rsp.fb_col      = result.fb_col;
  assign rsp.data_byte   = result.data_byte;
  assign rsp.last        = result.last;

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request and result sides open together");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.result_kind == RK_FRAME_BYTE && !rsp.last)
    |=> !req.ready)
    else $error("new request taken inside a frame read run");

  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_READ) |=> (rsp.valid || !req.ready))
    else $error("read request left without a result");

  a_display_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_kind == RK_DISPLAY) |-> !rsp.last)
    else $error("display write marked last");

endmodule
